[rtl/rgbmf_pkg.sv]
// Shared types, constants and compare helpers for the RGB 3x3 median filter.
package rgbmf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4095;
    localparam int MIN_DIM       = 3;
    localparam int RST_WIDTH     = 640;
    localparam int RST_HEIGHT    = 480;
    localparam int FIFO_DEPTH    = 8;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // config register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic [23:0]       t_pix;   // {R, G, B}
    typedef logic [8:0][23:0]  t_win;   // index = row * 3 + col

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic        frame_end;
    } t_pix_out;

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // {max, mid, min}
    function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        return {max3(a, b, c), med3(a, b, c), min3(a, b, c)};
    endfunction

endpackage

[rtl/rgb_median_filter_3x3.sv]
// Top level of the streaming RGB 3x3 median filter.
// Throughput: one item per clock while o_in_stall is low; each pixel item does one read
//   and one write of each line store, at the same column, so the RAM port pair sets the rate.
// Latency: a result passes stages 1 to 4 and the output FIFO after the item that causes
//   it is accepted; in pixel terms a result lags its input by one line plus one pixel.
// Reset (sync, active low): width 640, height 480, counters and window zero,
//   output FIFO empty. Line stores are not cleared and need no clearing pass.
module rgb_median_filter_3x3 #(
    parameter int MAX_WIDTH = rgbmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rgbmf_pkg::t_pix_in   i_in_data,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rgbmf_pkg::t_pix_out  o_out_data,
    // config write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [11:0]          i_cfg_data
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column index
    localparam int UW    = $clog2(rgbmf_pkg::FIFO_DEPTH + 1);
    localparam int RST_W = (rgbmf_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                               : rgbmf_pkg::RST_WIDTH;

    // per-result position / flags, carried alongside the data path
    typedef struct packed {
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
        logic        border;
    } t_meta;

    // ------------------------------------------------------------------
    // Frame geometry (stored as size minus one, already clamped)
    // ------------------------------------------------------------------
    logic [CW-1:0] r_wm1;
    logic [11:0]   r_hm1;
    logic [CW-1:0] n_wm1;
    logic [11:0]   n_hm1;

    always_comb begin
        int wv;
        int hv;
        wv = int'(i_cfg_data[10:0]);
        if (wv < rgbmf_pkg::MIN_DIM) wv = rgbmf_pkg::MIN_DIM;
        if (wv > MAX_WIDTH)          wv = MAX_WIDTH;
        hv = int'(i_cfg_data);
        if (hv < rgbmf_pkg::MIN_DIM)    hv = rgbmf_pkg::MIN_DIM;
        if (hv > rgbmf_pkg::MAX_HEIGHT) hv = rgbmf_pkg::MAX_HEIGHT;
        n_wm1 = CW'(wv - 1);
        n_hm1 = 12'(hv - 1);
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, position counters, line-store read issue
    // ------------------------------------------------------------------
    logic [11:0]   r_in_row,  n_in_row;
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [11:0]   r_out_row, n_out_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [UW-1:0] r_used;

    logic          accept;
    logic          fifo_pop;
    logic [CW-1:0] x;
    logic          drain_mode;
    logic          out_last;
    logic          emit;
    logic          adv_out;

    logic          s0_rd;
    logic          s0_pix;
    logic          s0_res;
    logic          s0_drain;
    logic          s0_selmid;
    logic [CW-1:0] s0_addr;
    t_meta         s0_meta;

    // credit: every result in flight or queued holds one FIFO slot
    assign o_in_stall = (r_used >= UW'(rgbmf_pkg::FIFO_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    assign x          = (r_in_col > r_wm1) ? '0 : r_in_col;
    assign drain_mode = (r_in_row > r_hm1);
    assign out_last   = (r_out_row == r_hm1) && (r_out_col == r_wm1);

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        s0_rd     = 1'b0;
        s0_pix    = 1'b0;
        s0_res    = 1'b0;
        s0_drain  = 1'b0;
        s0_selmid = 1'b0;
        s0_addr   = x;
        emit      = 1'b0;
        adv_out   = 1'b0;
        s0_meta.row    = r_out_row;
        s0_meta.col    = 10'(r_out_col);
        s0_meta.last   = out_last;
        s0_meta.border = (r_out_row == '0) || (r_out_row == r_hm1) ||
                         (r_out_col == '0) || (r_out_col == r_wm1);

        if (accept) begin
            if (drain_mode) begin
                if (r_out_row > r_hm1) begin
                    // nothing pending: restart the frame
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end else begin
                    // flush from the line stores; these pixels are all border
                    s0_rd     = 1'b1;
                    s0_res    = 1'b1;
                    s0_drain  = 1'b1;
                    s0_addr   = r_out_col;
                    s0_selmid = (r_out_row == r_hm1);
                    adv_out   = 1'b1;
                end
            end else if (i_in_data.req_type == rgbmf_pkg::REQ_PIXEL) begin
                s0_rd  = 1'b1;
                s0_pix = 1'b1;
                emit   = (r_in_row >= 12'd2) || ((r_in_row == 12'd1) && (x != '0));
                if (x == r_wm1) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 12'd1;
                end else begin
                    n_in_col = x + 1'b1;
                end
                if (emit) begin
                    s0_res  = 1'b1;
                    adv_out = 1'b1;
                end
            end
        end

        if (adv_out) begin
            if (out_last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else if (r_out_col == r_wm1) begin
                n_out_col = '0;
                n_out_row = r_out_row + 12'd1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1     <= CW'(RST_W - 1);
            r_hm1     <= 12'(rgbmf_pkg::RST_HEIGHT - 1);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_used    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rgbmf_pkg::CFG_IMAGE_WIDTH:  r_wm1 <= n_wm1;
                    rgbmf_pkg::CFG_IMAGE_HEIGHT: r_hm1 <= n_hm1;
                endcase
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else begin
                r_in_row  <= n_in_row;
                r_in_col  <= n_in_col;
                r_out_row <= n_out_row;
                r_out_col <= n_out_col;
            end
            r_used <= r_used + UW'(accept && s0_res) - UW'(fifo_pop);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line-store data back, write-back, window shift
    // ------------------------------------------------------------------
    logic            r_s1_pix;
    logic            r_s1_res;
    logic            r_s1_drain;
    logic            r_s1_selmid;
    logic [CW-1:0]   r_s1_addr;
    rgbmf_pkg::t_pix r_s1_data;
    t_meta           r_s1_meta;

    rgbmf_pkg::t_pix up_rd;
    rgbmf_pkg::t_pix mid_rd;
    rgbmf_pkg::t_pix up_q;
    rgbmf_pkg::t_pix mid_q;

    // read issued in the same cycle as a write to the same column
    logic            r_fwd;
    rgbmf_pkg::t_pix r_fwd_up;
    rgbmf_pkg::t_pix r_fwd_mid;

    assign up_q  = r_fwd ? r_fwd_up  : up_rd;
    assign mid_q = r_fwd ? r_fwd_mid : mid_rd;

    rgbmf_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_pix),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_q),
        .i_re    (s0_rd),
        .i_raddr (s0_addr),
        .o_rdata (up_rd)
    );

    rgbmf_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_ram_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_pix),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_data),
        .i_re    (s0_rd),
        .i_raddr (s0_addr),
        .o_rdata (mid_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pix <= 1'b0;
            r_s1_res <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            r_s1_pix <= s0_pix;
            r_s1_res <= s0_res;
            r_fwd    <= s0_rd && r_s1_pix && (s0_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_drain  <= s0_drain;
        r_s1_selmid <= s0_selmid;
        r_s1_addr   <= s0_addr;
        r_s1_data   <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        r_s1_meta   <= s0_meta;
        r_fwd_up    <= mid_q;
        r_fwd_mid   <= r_s1_data;
    end

    rgbmf_pkg::t_win r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_pix) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= up_q;
            r_win[5] <= mid_q;
            r_win[8] <= r_s1_data;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2..4: median over the updated window, border bypass
    // ------------------------------------------------------------------
    logic            r_s2_vld;
    logic            r_s2_drain;
    rgbmf_pkg::t_pix r_s2_dpix;
    t_meta           r_s2_meta;

    logic            r_s3_vld;
    logic            r_s3_byp;
    rgbmf_pkg::t_pix r_s3_center;
    t_meta           r_s3_meta;

    logic            r_s4_vld;
    logic            r_s4_byp;
    rgbmf_pkg::t_pix r_s4_center;
    t_meta           r_s4_meta;

    rgbmf_pkg::t_pix     med;
    rgbmf_pkg::t_pix     res_pix;
    rgbmf_pkg::t_pix_out res;

    rgbmf_median u_median (
        .i_clk (i_clk),
        .i_win (r_win),
        .o_med (med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_res;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_drain  <= r_s1_drain;
        r_s2_dpix   <= r_s1_selmid ? mid_q : up_q;
        r_s2_meta   <= r_s1_meta;
        // drain pixels come straight from the line stores
        r_s3_center <= r_s2_drain ? r_s2_dpix : r_win[4];
        r_s3_byp    <= r_s2_drain || r_s2_meta.border;
        r_s3_meta   <= r_s2_meta;
        r_s4_center <= r_s3_center;
        r_s4_byp    <= r_s3_byp;
        r_s4_meta   <= r_s3_meta;
    end

    assign res_pix       = r_s4_byp ? r_s4_center : med;
    assign res.red_out   = res_pix[23:16];
    assign res.green_out = res_pix[15:8];
    assign res.blue_out  = res_pix[7:0];
    assign res.out_row   = r_s4_meta.row;
    assign res.out_col   = r_s4_meta.col;
    assign res.frame_end = r_s4_meta.last;

    rgbmf_out_fifo #(
        .DEPTH (rgbmf_pkg::FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s4_vld),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data),
        .o_pop   (fifo_pop)
    );

endmodule

[rtl/rgbmf_line_ram.sv]
// One line store: synchronous RAM, one write port, one registered read port.
module rgbmf_line_ram #(
    parameter int DEPTH = rgbmf_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  rgbmf_pkg::t_pix      i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output rgbmf_pkg::t_pix      o_rdata
);

    rgbmf_pkg::t_pix r_mem [DEPTH];
    rgbmf_pkg::t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rgbmf_median.sv]
// Two-stage 3x3 median per channel: column sort, then max/med/min merge.
module rgbmf_median (
    input  logic             i_clk,
    input  rgbmf_pkg::t_win  i_win,
    output rgbmf_pkg::t_pix  o_med
);

    // r_srt[ch][col] = {max, mid, min}
    logic [2:0][2:0][23:0] r_srt;
    logic [2:0][7:0]       r_med;

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 3; c++) begin
                r_srt[ch][c] <= rgbmf_pkg::sort3(i_win[c][ch*8 +: 8],
                                                 i_win[3+c][ch*8 +: 8],
                                                 i_win[6+c][ch*8 +: 8]);
            end
        end

        always_ff @(posedge i_clk) begin
            r_med[ch] <= rgbmf_pkg::med3(
                rgbmf_pkg::max3(r_srt[ch][0][7:0], r_srt[ch][1][7:0], r_srt[ch][2][7:0]),
                rgbmf_pkg::med3(r_srt[ch][0][15:8], r_srt[ch][1][15:8],
                                r_srt[ch][2][15:8]),
                rgbmf_pkg::min3(r_srt[ch][0][23:16], r_srt[ch][1][23:16],
                                r_srt[ch][2][23:16]));
        end
    end

    assign o_med = {r_med[2], r_med[1], r_med[0]};

endmodule

[rtl/rgbmf_out_fifo.sv]
// Small result FIFO at the output; space is reserved by the top-level credit count.
module rgbmf_out_fifo #(
    parameter int DEPTH = rgbmf_pkg::FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rgbmf_pkg::t_pix_out  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rgbmf_pkg::t_pix_out  o_data,
    output logic                 o_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rgbmf_pkg::t_pix_out r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_pop   = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (o_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(o_pop);
        end
    end

endmodule

[dv/testbench.sv]
// Self-checking testbench for the streaming RGB 3x3 median filter.
`timescale 1ns / 100ps

module testbench;

    localparam int HOLD_CYCLES   = 300;     // long output hold-off
    localparam int SETTLE_CYCLES = 8;       // settle time for items still in flight
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 36;
    localparam int RANDOM_ITEMS  = 340;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    rgbmf_pkg::t_pix_in   in_item  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    rgbmf_pkg::t_pix_out  out_item;
    logic                 cfg_we   = 1'b0;
    logic                 cfg_idx  = rgbmf_pkg::CFG_IMAGE_WIDTH;
    logic [11:0]          cfg_data = '0;

    rgb_median_filter_3x3 #(
        .MAX_WIDTH (rgbmf_pkg::MAX_WIDTH_DEF)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter predictor: own copy of the size registers, line stores,
    // 3x3 window and raster counters
    // ------------------------------------------------------------------
    logic [10:0]         width_reg  = 11'(rgbmf_pkg::RST_WIDTH);
    logic [11:0]         height_reg = 12'(rgbmf_pkg::RST_HEIGHT);
    rgbmf_pkg::t_pix     top_line [rgbmf_pkg::MAX_WIDTH_DEF] = '{default: '0};   // row r-2
    rgbmf_pkg::t_pix     mid_line [rgbmf_pkg::MAX_WIDTH_DEF] = '{default: '0};   // row r-1
    rgbmf_pkg::t_pix     win [9] = '{default: '0};                    // row * 3 + col
    int unsigned         row_in;
    int unsigned         col_in;
    int unsigned         out_idx;
    rgbmf_pkg::t_pix_out pending_pixels [$];    // filtered pixels still owed by the DUT

    int unsigned         counted_items;         // items the block actually acted on
    int unsigned         num_errors;
    int unsigned         cycle_count;
    bit                  tx_idle_on = 1'b1;
    bit                  rx_idle_on = 1'b1;
    bit                  hold_req;
    int unsigned         hold_left;
    rgbmf_pkg::t_pix_out want_px;

    // out-of-range sizes saturate
    function automatic int unsigned eff_width();
        int unsigned v;
        v = 32'(width_reg);
        if (v < rgbmf_pkg::MIN_DIM) v = rgbmf_pkg::MIN_DIM;
        if (v > rgbmf_pkg::MAX_WIDTH_DEF) v = rgbmf_pkg::MAX_WIDTH_DEF;
        return v;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned v;
        v = 32'(height_reg);
        if (v < rgbmf_pkg::MIN_DIM) v = rgbmf_pkg::MIN_DIM;
        if (v > rgbmf_pkg::MAX_HEIGHT) v = rgbmf_pkg::MAX_HEIGHT;
        return v;
    endfunction

    function automatic void restart_frame();
        row_in  = 0;
        col_in  = 0;
        out_idx = 0;
    endfunction

    // median of one channel over the nine window taps
    function automatic logic [7:0] window_median(int lsb);
        logic [7:0] v [9];
        logic [7:0] t;
        for (int i = 0; i < 9; i++) v[i] = win[i][lsb +: 8];
        for (int i = 1; i < 9; i++)
            for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
                t      = v[j];
                v[j]   = v[j-1];
                v[j-1] = t;
            end
        return v[4];
    endfunction

    function automatic void emit_pixel(rgbmf_pkg::t_pix px, int unsigned w, int unsigned h);
        rgbmf_pkg::t_pix_out r;
        r.red_out   = px[23:16];
        r.green_out = px[15:8];
        r.blue_out  = px[7:0];
        r.out_row   = 12'(out_idx / w);
        r.out_col   = 10'(out_idx % w);
        r.frame_end = (out_idx == w * h - 1);
        pending_pixels.insert(pending_pixels.size(), r);
        if (r.frame_end) restart_frame();
        else out_idx++;
    endfunction

    // Advances the model by one accepted item; returns 1 unless the item
    // was simply ignored.
    function automatic bit predict_filtered_pixel(rgbmf_pkg::t_pix_in item);
        int unsigned     w, h, x, orow, ocol;
        rgbmf_pkg::t_pix px;
        bit              emit;
        w = eff_width();
        h = eff_height();

        // whole frame in: every item (pixel or drain) flushes one output
        if (row_in >= h) begin
            if (out_idx >= w * h) begin
                restart_frame();
                return 1'b0;
            end
            ocol = out_idx % w;
            px = (out_idx / w == h - 1) ? mid_line[ocol] : top_line[ocol];
            emit_pixel(px, w, h);
            return 1'b1;
        end

        // drain while the frame is still arriving does nothing
        if (item.req_type == rgbmf_pkg::REQ_DRAIN) return 1'b0;

        x  = (col_in >= w) ? 0 : col_in;
        px = {item.red_in, item.green_in, item.blue_in};
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2]      = top_line[x];
        win[5]      = mid_line[x];
        win[8]      = px;
        top_line[x] = mid_line[x];
        mid_line[x] = px;

        emit = (row_in >= 2) || (row_in == 1 && x >= 1);
        if (x + 1 >= w) begin
            col_in = 0;
            row_in++;
        end else begin
            col_in = x + 1;
        end

        if (emit) begin
            orow = out_idx / w;
            ocol = out_idx % w;
            // interior pixels are filtered, the border passes through
            if (orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w)
                px = {window_median(16), window_median(8), window_median(0)};
            else
                px = win[4];
            emit_pixel(px, w, h);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Item generation and driving
    // ------------------------------------------------------------------
    // coarse levels give lots of ties inside the window
    function automatic logic [7:0] rand_chan(bit coarse);
        if (!coarse) return 8'($urandom_range(255));
        case ($urandom_range(2))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'h7F;
        endcase
    endfunction

    function automatic rgbmf_pkg::t_pix_in make_pixel(bit coarse);
        rgbmf_pkg::t_pix_in p;
        p.req_type = rgbmf_pkg::REQ_PIXEL;
        p.red_in   = rand_chan(coarse);
        p.green_in = rand_chan(coarse);
        p.blue_in  = rand_chan(coarse);
        return p;
    endfunction

    function automatic rgbmf_pkg::t_pix_in make_drain();
        rgbmf_pkg::t_pix_in p;
        p = make_pixel(1'b0);           // payload is don't-care
        p.req_type = rgbmf_pkg::REQ_DRAIN;
        return p;
    endfunction

    // Offers one item and returns at the edge where it is taken. valid is
    // left high so back-to-back items need no extra edge.
    task automatic push_item(input rgbmf_pkg::t_pix_in item);
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        if (predict_filtered_pixel(item)) counted_items++;
    endtask

    // n_px pixels (with stray drains mixed in), then n_flush items of the
    // flush phase; some flush items are pixels, which must be discarded
    task automatic send_frame(input int unsigned n_px, input int unsigned n_flush,
                              input bit coarse, input int stray_pct);
        for (int unsigned i = 0; i < n_px; i++) begin
            if ($urandom_range(99) < stray_pct) push_item(make_drain());
            push_item(make_pixel(coarse));
        end
        for (int unsigned i = 0; i < n_flush; i++)
            push_item(($urandom_range(99) < 30) ? make_pixel(coarse) : make_drain());
    endtask

    // all owed pixels out, then room for items still in flight with no result
    task automatic wait_idle();
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] value);
        in_valid <= 1'b0;
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rgbmf_pkg::CFG_IMAGE_WIDTH) width_reg = value[10:0];
        else height_reg = value;
        restart_frame();
    endtask

    task automatic set_size(input logic [11:0] w, input logic [11:0] h);
        write_reg(rgbmf_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(rgbmf_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [11:0] rand_dim(int unsigned hi);
        if ($urandom_range(99) < 10) return 12'($urandom_range(2));   // saturates to 3
        return 12'($urandom_range(hi, rgbmf_pkg::MIN_DIM));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off counted here
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each taken item against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                if (num_errors < 10)
                    $display("unexpected output item: %p", out_item);
                num_errors++;
            end else begin
                want_px = pending_pixels.pop_front();
                if (out_item.red_out   !== want_px.red_out   ||
                    out_item.green_out !== want_px.green_out ||
                    out_item.blue_out  !== want_px.blue_out  ||
                    out_item.out_row   !== want_px.out_row   ||
                    out_item.out_col   !== want_px.out_col   ||
                    out_item.frame_end !== want_px.frame_end) begin
                    if (num_errors < 10)
                        $display({"mismatch: want %h_%h_%h r%0d c%0d e%0b,",
                                  " got %h_%h_%h r%0d c%0d e%0b"},
                                 want_px.red_out, want_px.green_out, want_px.blue_out,
                                 want_px.out_row, want_px.out_col, want_px.frame_end,
                                 out_item.red_out, out_item.green_out, out_item.blue_out,
                                 out_item.out_row, out_item.out_col, out_item.frame_end);
                    num_errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset size (640 wide): part of row 0, no result may appear yet;
    // cut short by the next register write
    task automatic test_power_on_size();
        send_frame(40, 0, 1'b0, 0);
    endtask

    // 3x3 frame: only the center is filtered; channel extremes, an early
    // drain, a drain mid-frame, a pixel during flush, end of frame
    task automatic test_directed_frame();
        logic [7:0] red_v [9] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F,
                                  8'hFE, 8'h10, 8'h20, 8'h40};
        logic [7:0] grn_v [9] = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                  8'h00, 8'h55, 8'hAA, 8'h55};
        logic [7:0] blu_v [9] = '{8'h12, 8'h12, 8'h12, 8'h12, 8'h34,
                                  8'h56, 8'h78, 8'h9A, 8'hBC};
        rgbmf_pkg::t_pix_in px;
        set_size(12'd3, 12'd3);
        push_item(make_drain());                // nothing pending: no result
        for (int i = 0; i < 9; i++) begin
            px.req_type = rgbmf_pkg::REQ_PIXEL;
            px.red_in   = red_v[i];
            px.green_in = grn_v[i];
            px.blue_in  = blu_v[i];
            push_item(px);
            if (i == 4) push_item(make_drain()); // ignored mid-frame
        end
        push_item(make_pixel(1'b0));            // frame complete: acts as drain
        repeat (3) push_item(make_drain());     // last one carries frame_end
        push_item(make_drain());                // counters back at zero
    endtask

    // output held off for a long stretch while items keep coming: the
    // output queue fills and the input must stall
    task automatic test_output_hold_off();
        set_size(12'd5, 12'd4);
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        send_frame(20, 6, 1'b0, 0);
        send_frame(20, 6, 1'b1, 0);
        tx_idle_on = 1'b1;
    endtask

    // size extremes, including out-of-range values that saturate
    task automatic test_size_extremes();
        set_size(12'hFFF, 12'd3);                       // width saturates to max
        send_frame(30, 0, 1'b0, 0);                     // cut short
        set_size(12'd0, 12'd0);                         // both saturate to 3
        send_frame(9, 4, 1'b1, 0);
        // tallest frame, cut short, with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_size(12'd0, 12'(rgbmf_pkg::MAX_HEIGHT));
        send_frame(60, 0, 1'b1, 0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // mostly complete small frames with random content; a few are cut short
    // by a register write, which restarts the frame
    task automatic test_random_frames();
        int unsigned frame_no;
        int unsigned w, h;
        bit          must_write;
        bit          coarse;
        frame_no      = 0;
        must_write    = 1'b1;
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            tx_idle_on = (frame_no < 6 || frame_no > 11);
            rx_idle_on = tx_idle_on;
            if (must_write || $urandom_range(99) < 60)
                set_size(rand_dim(12), rand_dim(8));
            w      = eff_width();
            h      = eff_height();
            coarse = ($urandom_range(3) == 0);
            must_write = ($urandom_range(9) == 0);
            if (must_write)
                send_frame($urandom_range(w * h - 1), 0, coarse, 5);
            else
                send_frame(w * h, w + 1, coarse, 5);
            frame_no++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_on_size();
        test_directed_frame();
        test_output_hold_off();
        test_size_extremes();
        test_random_frames();
        in_valid <= 1'b0;
        wait_idle();
        if (num_errors == 0 && pending_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
